@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies c in the same cycle
`define AST_SAME(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("assertion failed");

// a implies c in the next cycle
`define AST_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ hdl/nfca_pkg.sv @@
// Constants and codes for the next-fit chunk allocator.
// No dependencies.
`default_nettype none
package nfca_pkg;
  localparam int ARENA_BYTES_DEF  = 65536;
  localparam int HEADER_BYTES_DEF = 48;
  localparam int SIZE_W           = 28;
  localparam logic [31:0] FREE_MARK  = 32'h8000_0000;
  localparam logic [31:0] SIZE_FIELD = 32'h0FFF_FFFF;
  localparam logic [1:0]  ROUND_MASK = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;
endpackage
`default_nettype wire

@@ hdl/next_fit_chunk_allocator.sv @@
// Next-fit boundary-tag chunk allocator, top level.
// Uses nfca_pkg, nfca_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// A request is taken when start is high and busy is low; its result appears on
// the out_ ports for one cycle with out_valid and cannot be held off. After
// reset a clearing pass writes every header word, with busy high. A zero-size
// allocate or a malformed release address is answered with out_valid in the
// next cycle. An allocate reads the chunk headers its search visits (a
// whole-chunk grant adds a header write plus a second walk to the next free
// chunk); a split adds the new free header and relinks any chunk after it. A
// release merges the freed chunk with a free next and a free previous chunk. All
// header traffic goes through one single-port memory, one access per cycle.
module next_fit_chunk_allocator #(
  parameter int ARENA_BYTES  = nfca_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = nfca_pkg::HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [16:0] in_request_size,
  input  wire logic [15:0] in_free_address,
  output logic             out_valid,
  output logic      [15:0] out_data_offset,
  output logic      [1:0]  out_status,
  output logic      [16:0] out_bytes_in_use,
  output logic      [11:0] out_chunks_in_use
);
  localparam int SLOTS = ARENA_BYTES / 4;
  localparam int AW    = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int SW    = nfca_pkg::SIZE_W;
  localparam int UW0   = $clog2(ARENA_BYTES + 1);
  localparam int UW    = (UW0 > 17) ? UW0 : 17;
  localparam int CW0   = $clog2(SLOTS + 1);
  localparam int CW    = (CW0 > 12) ? CW0 : 12;

  typedef struct packed {
    logic          head;
    logic [LW-1:0] link;
    logic          free;
    logic [SW-1:0] size;
  } hdr_t;
  localparam int DW = $bits(hdr_t);

  typedef enum logic [17:0] {
    S_CLR   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_WRD   = 18'h00004,
    S_WALK  = 18'h00008,
    S_SNW   = 18'h00010,
    S_SARD  = 18'h00020,
    S_SAWR  = 18'h00040,
    S_RH    = 18'h00080,
    S_RNRD  = 18'h00100,
    S_RN    = 18'h00200,
    S_RNCLR = 18'h00400,
    S_RARD  = 18'h00800,
    S_RAWR  = 18'h01000,
    S_RPRD  = 18'h02000,
    S_RP    = 18'h04000,
    S_RPCLR = 18'h08000,
    S_RP2RD = 18'h10000,
    S_RP2WR = 18'h20000
  } state_t;

  function automatic logic [AW:0] span(input logic [SW-1:0] s);
    logic [SW:0] t;
    t = {1'b0, s} + (SW+1)'(HEADER_BYTES);
    return (AW+1)'(t >> 2);
  endfunction

  function automatic logic [LW-1:0] lnk(input logic [AW-1:0] idx);
    return LW'(idx) + LW'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     act_r, act_nxt, strt_r, strt_nxt, at_r, at_nxt;
  logic [AW-1:0]     tmp_r, tmp_nxt, clr_r, clr_nxt, rover_r, rover_nxt;
  logic [AW:0]       nw_r, nw_nxt;
  logic              wrap_r, wrap_nxt, srch_r, srch_nxt, hnext_r, hnext_nxt;
  logic              rval_r, rval_nxt, ov_r, ov_nxt;
  logic [SW-1:0]     req_r, req_nxt, size_r, size_nxt;
  logic [LW-1:0]     hlink_r, hlink_nxt;
  logic [UW-1:0]     used_r, used_nxt, off_r, off_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [15:0]       ooff_r, ooff_nxt;
  nfca_pkg::status_t ost_r, ost_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  hdr_t          mem_wd, rd;
  logic [DW-1:0] ram_q;

  logic [AW:0]   step, after;
  logic [SW-1:0] left, merged;
  logic [SW:0]   rnd;
  logic [15:0]   rel;
  logic [13:0]   hw14;
  logic          hit;

  assign rd = hdr_t'(ram_q);

  nfca_ram #(.DEPTH(SLOTS), .AW(AW), .DW(DW)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wd   (mem_wd),
    .rd   (ram_q)
  );

  always_comb begin
    state_nxt = state_r;  act_nxt = act_r;   strt_nxt = strt_r;  at_nxt = at_r;
    tmp_nxt = tmp_r;      clr_nxt = clr_r;   rover_nxt = rover_r; nw_nxt = nw_r;
    wrap_nxt = wrap_r;    srch_nxt = srch_r; hnext_nxt = hnext_r; rval_nxt = rval_r;
    req_nxt = req_r;      size_nxt = size_r; hlink_nxt = hlink_r; used_nxt = used_r;
    off_nxt = off_r;      cnt_nxt = cnt_r;   ooff_nxt = ooff_r;   ost_nxt = ost_r;
    ov_nxt = 1'b0;
    mem_we = 1'b0;  mem_re = 1'b0;  mem_addr = act_r;  mem_wd = '0;
    hit = rd.free && (rd.size >= req_r);
    step = {1'b0, act_r} + span(rd.size);
    after = {1'b0, act_r} + span(rd.size);
    left = rd.size - req_r;
    merged = '0;
    rnd = ({1'b0, 11'd0, in_request_size} + (SW+1)'(nfca_pkg::ROUND_MASK))
          & ~(SW+1)'(nfca_pkg::ROUND_MASK);
    rel = in_free_address - 16'(HEADER_BYTES);
    hw14 = rel[15:2];
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_addr = clr_r;
        if (clr_r == '0) begin
          mem_wd = '{head: 1'b1, link: '0, free: 1'b1,
                     size: SW'(ARENA_BYTES - HEADER_BYTES)};
        end
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (!in_op) begin
            if (in_request_size == '0) begin
              ov_nxt = 1'b1;  ooff_nxt = '0;  ost_nxt = nfca_pkg::ST_ZERO;
            end else begin
              req_nxt = SW'(rnd);
              srch_nxt = 1'b0;
              wrap_nxt = 1'b0;
              act_nxt = rval_r ? rover_r : '0;
              strt_nxt = rval_r ? rover_r : '0;
              state_nxt = S_WRD;
            end
          end else if ((in_free_address < 16'(HEADER_BYTES)) ||
                       (in_free_address[1:0] != 2'd0) ||
                       (32'(hw14) >= 32'(SLOTS))) begin
            ov_nxt = 1'b1;  ooff_nxt = '0;  ost_nxt = nfca_pkg::ST_BADFREE;
          end else begin
            at_nxt = AW'(hw14);
            mem_re = 1'b1;
            mem_addr = AW'(hw14);
            state_nxt = S_RH;
          end
        end
      end
      S_WRD: begin
        mem_re = 1'b1;
        mem_addr = act_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (hit && srch_r) begin
          rover_nxt = act_r;  rval_nxt = 1'b1;
          ov_nxt = 1'b1;  ooff_nxt = off_r[15:0];  ost_nxt = nfca_pkg::ST_OK;
          state_nxt = S_IDLE;
        end else if (hit) begin
          at_nxt = act_r;
          off_nxt = UW'({act_r, 2'b00}) + UW'(HEADER_BYTES);
          mem_we = 1'b1;
          mem_addr = act_r;
          if (left > SW'(HEADER_BYTES)) begin
            mem_wd = '{head: 1'b1, link: rd.link, free: 1'b0, size: req_r};
            nw_nxt = {1'b0, act_r} + span(req_r);
            size_nxt = left - SW'(HEADER_BYTES);
            tmp_nxt = AW'(after);
            hnext_nxt = after < (AW+1)'(SLOTS);
            state_nxt = S_SNW;
          end else begin
            mem_wd = '{head: 1'b1, link: rd.link, free: 1'b0, size: rd.size};
            used_nxt = used_r + UW'(rd.size);
            srch_nxt = 1'b1;
            req_nxt = '0;
            wrap_nxt = 1'b0;
            strt_nxt = act_r;
            state_nxt = S_WRD;
          end
        end else begin
          wrap_nxt = wrap_r;
          if (step >= (AW+1)'(SLOTS)) begin
            step = '0;
            wrap_nxt = 1'b1;
          end
          if (wrap_nxt && (step >= {1'b0, strt_r})) begin
            rval_nxt = 1'b0;
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
            if (srch_r) begin
              rover_nxt = '0;
              ooff_nxt = off_r[15:0];
              ost_nxt = nfca_pkg::ST_OK;
            end else begin
              ooff_nxt = '0;
              ost_nxt = nfca_pkg::ST_NOSPACE;
            end
          end else begin
            act_nxt = AW'(step);
            mem_re = 1'b1;
            mem_addr = AW'(step);
          end
        end
      end
      S_SNW: begin
        mem_we = 1'b1;
        mem_addr = AW'(nw_r);
        mem_wd = '{head: 1'b1, link: lnk(at_r), free: 1'b1, size: size_r};
        rover_nxt = AW'(nw_r);
        rval_nxt = 1'b1;
        used_nxt = used_r + UW'(req_r) + UW'(HEADER_BYTES);
        cnt_nxt = cnt_r + CW'(1);
        if (hnext_r) begin
          state_nxt = S_SARD;
        end else begin
          ov_nxt = 1'b1;  ooff_nxt = off_r[15:0];  ost_nxt = nfca_pkg::ST_OK;
          state_nxt = S_IDLE;
        end
      end
      S_SARD: begin
        mem_re = 1'b1;
        mem_addr = tmp_r;
        state_nxt = S_SAWR;
      end
      S_SAWR: begin
        mem_we = 1'b1;
        mem_addr = tmp_r;
        mem_wd = '{head: rd.head, link: lnk(AW'(nw_r)), free: rd.free, size: rd.size};
        ov_nxt = 1'b1;  ooff_nxt = off_r[15:0];  ost_nxt = nfca_pkg::ST_OK;
        state_nxt = S_IDLE;
      end
      S_RH: begin
        if (!rd.head || rd.free) begin
          ov_nxt = 1'b1;  ooff_nxt = '0;  ost_nxt = nfca_pkg::ST_BADFREE;
          state_nxt = S_IDLE;
        end else begin
          size_nxt = rd.size;
          hlink_nxt = rd.link;
          used_nxt = used_r - UW'(rd.size);
          mem_we = 1'b1;
          mem_addr = at_r;
          mem_wd = '{head: 1'b1, link: rd.link, free: 1'b1, size: rd.size};
          nw_nxt = {1'b0, at_r} + span(rd.size);
          if (({1'b0, at_r} + span(rd.size)) < (AW+1)'(SLOTS)) begin
            state_nxt = S_RNRD;
          end else begin
            hnext_nxt = 1'b0;
            state_nxt = S_RPRD;
          end
        end
      end
      S_RNRD: begin
        mem_re = 1'b1;
        mem_addr = AW'(nw_r);
        state_nxt = S_RN;
      end
      S_RN: begin
        hnext_nxt = 1'b1;
        state_nxt = S_RPRD;
        if (rd.free) begin
          merged = size_r + rd.size + SW'(HEADER_BYTES);
          size_nxt = merged;
          mem_we = 1'b1;
          mem_addr = at_r;
          mem_wd = '{head: 1'b1, link: hlink_r, free: 1'b1, size: merged};
          tmp_nxt = AW'(nw_r);
          nw_nxt = nw_r + span(rd.size);
          hnext_nxt = (nw_r + span(rd.size)) < (AW+1)'(SLOTS);
          if (rval_r && (rover_r == AW'(nw_r))) begin
            rover_nxt = at_r;
          end
          used_nxt = used_r - UW'(HEADER_BYTES);
          cnt_nxt = cnt_r - CW'(1);
          state_nxt = S_RNCLR;
        end
      end
      S_RNCLR: begin
        mem_we = 1'b1;
        mem_addr = tmp_r;
        state_nxt = hnext_r ? S_RARD : S_RPRD;
      end
      S_RARD: begin
        mem_re = 1'b1;
        mem_addr = AW'(nw_r);
        state_nxt = S_RAWR;
      end
      S_RAWR: begin
        mem_we = 1'b1;
        mem_addr = AW'(nw_r);
        mem_wd = '{head: rd.head, link: lnk(at_r), free: rd.free, size: rd.size};
        state_nxt = S_RPRD;
      end
      S_RPRD: begin
        if ((hlink_r != '0) && (hlink_r <= LW'(SLOTS))) begin
          tmp_nxt = AW'(hlink_r - LW'(1));
          mem_re = 1'b1;
          mem_addr = AW'(hlink_r - LW'(1));
          state_nxt = S_RP;
        end else begin
          ov_nxt = 1'b1;  ooff_nxt = '0;  ost_nxt = nfca_pkg::ST_OK;
          state_nxt = S_IDLE;
        end
      end
      S_RP: begin
        if (rd.free) begin
          merged = rd.size + size_r + SW'(HEADER_BYTES);
          mem_we = 1'b1;
          mem_addr = tmp_r;
          mem_wd = '{head: 1'b1, link: rd.link, free: 1'b1, size: merged};
          if (rval_r && (rover_r == at_r)) begin
            rover_nxt = tmp_r;
          end
          used_nxt = used_r - UW'(HEADER_BYTES);
          cnt_nxt = cnt_r - CW'(1);
          state_nxt = S_RPCLR;
        end else begin
          ov_nxt = 1'b1;  ooff_nxt = '0;  ost_nxt = nfca_pkg::ST_OK;
          state_nxt = S_IDLE;
        end
      end
      S_RPCLR: begin
        mem_we = 1'b1;
        mem_addr = at_r;
        if (hnext_r) begin
          state_nxt = S_RP2RD;
        end else begin
          ov_nxt = 1'b1;  ooff_nxt = '0;  ost_nxt = nfca_pkg::ST_OK;
          state_nxt = S_IDLE;
        end
      end
      S_RP2RD: begin
        mem_re = 1'b1;
        mem_addr = AW'(nw_r);
        state_nxt = S_RP2WR;
      end
      S_RP2WR: begin
        mem_we = 1'b1;
        mem_addr = AW'(nw_r);
        mem_wd = '{head: rd.head, link: lnk(tmp_r), free: rd.free, size: rd.size};
        ov_nxt = 1'b1;  ooff_nxt = '0;  ost_nxt = nfca_pkg::ST_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      rover_r <= '0;
      rval_r  <= 1'b1;
      used_r  <= UW'(HEADER_BYTES);
      cnt_r   <= CW'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      rover_r <= rover_nxt;
      rval_r  <= rval_nxt;
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    strt_r  <= strt_nxt;
    at_r    <= at_nxt;
    tmp_r   <= tmp_nxt;
    nw_r    <= nw_nxt;
    wrap_r  <= wrap_nxt;
    srch_r  <= srch_nxt;
    hnext_r <= hnext_nxt;
    req_r   <= req_nxt;
    size_r  <= size_nxt;
    hlink_r <= hlink_nxt;
    off_r   <= off_nxt;
    ooff_r  <= ooff_nxt;
    ost_r   <= ost_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_data_offset   = ooff_r;
  assign out_status        = ost_r;
  assign out_bytes_in_use  = used_r[16:0];
  assign out_chunks_in_use = cnt_r[11:0];

  `AST_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy || out_valid)
  `AST_SAME(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `AST_SAME(a_nospace_zero, clk, rst_n, out_valid && (out_status == nfca_pkg::ST_NOSPACE), out_data_offset == 16'd0)
  `AST_SAME(a_count_nonzero, clk, rst_n, !busy, cnt_r != '0)
endmodule
`default_nettype wire

@@ hdl/nfca_ram.sv @@
// Single-port header memory with registered read data.
// No dependencies.
`default_nettype none
module nfca_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 45
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wd,
  output logic      [DW-1:0] rd
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    if (re) begin
      rd <= mem[addr];
    end
  end
endmodule
`default_nettype wire

@@ verif/tb_next_fit_chunk_allocator.sv @@
// Self-checking testbench for next_fit_chunk_allocator: a clocked driver and monitor
// compare each result against an in-bench model of the chunk arena.
// Depends on nfca_pkg and the next_fit_chunk_allocator RTL.
`default_nettype none
module tb_next_fit_chunk_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ARENA = nfca_pkg::ARENA_BYTES_DEF;
  localparam int unsigned HB    = nfca_pkg::HEADER_BYTES_DEF;
  localparam int unsigned SLOTS = ARENA / 4;
  localparam int unsigned CYCLE_LIMIT = 30_000_000;
  localparam int unsigned N_RANDOM = 1850;

  typedef struct {
    logic        op;
    logic [16:0] size;
    logic [15:0] addr;
  } request_t;

  typedef struct {
    logic [15:0]       offset;
    nfca_pkg::status_t status;
    logic [16:0]       used;
    logic [11:0]       chunks;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [16:0] in_request_size = '0;
  logic [15:0] in_free_address = '0;
  logic out_valid;
  logic [15:0] out_data_offset;
  logic [1:0] out_status;
  logic [16:0] out_bytes_in_use;
  logic [11:0] out_chunks_in_use;

  next_fit_chunk_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_request_size(in_request_size), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_data_offset(out_data_offset), .out_status(out_status),
    .out_bytes_in_use(out_bytes_in_use), .out_chunks_in_use(out_chunks_in_use)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // arena model
  int unsigned hdr [SLOTS];
  int unsigned back [SLOTS];
  bit          here [SLOTS];
  int unsigned rover;
  bit          rover_ok;
  int unsigned used_bytes;
  int unsigned n_chunks;
  int unsigned live_offsets [$];

  request_t pending [$];
  grant_t   grants_due [$];
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  bit stim_done = 1'b0;

  function automatic int unsigned span(int unsigned w);
    return ((hdr[w] & nfca_pkg::SIZE_FIELD) + HB) / 4;
  endfunction

  function automatic bit find_free(int unsigned from, int unsigned need_bytes,
                                   output int unsigned found);
    int unsigned w;
    bit wrapped;
    w = (from >= SLOTS) ? 0 : from;
    wrapped = 1'b0;
    found = 0;
    forever begin
      if ((hdr[w] & nfca_pkg::FREE_MARK) != 0 &&
          (hdr[w] & nfca_pkg::SIZE_FIELD) >= need_bytes) begin
        found = w;
        return 1'b1;
      end
      w += span(w);
      if (w >= SLOTS) begin
        w = 0;
        wrapped = 1'b1;
      end
      if (wrapped && w >= from) return 1'b0;
    end
  endfunction

  function automatic void arena_reset();
    for (int i = 0; i < SLOTS; i++) begin
      hdr[i] = 0;
      back[i] = 0;
      here[i] = 0;
    end
    hdr[0] = nfca_pkg::FREE_MARK | ((ARENA - HB) & nfca_pkg::SIZE_FIELD);
    here[0] = 1'b1;
    rover = 0;
    rover_ok = 1'b1;
    used_bytes = HB;
    n_chunks = 1;
  endfunction

  function automatic void arena_alloc(int unsigned req, ref grant_t g);
    int unsigned at, sz, left, nw, after, nxt;
    if (req == 0) begin
      g.status = nfca_pkg::ST_ZERO;
      return;
    end
    req = (req + nfca_pkg::ROUND_MASK) & ~32'(nfca_pkg::ROUND_MASK);
    if (!find_free(rover_ok ? rover : 0, req, at)) begin
      rover_ok = 1'b0;
      g.status = nfca_pkg::ST_NOSPACE;
      return;
    end
    sz = hdr[at] & nfca_pkg::SIZE_FIELD;
    left = sz - req;
    if (left > HB) begin
      nw = at + (req + HB) / 4;
      hdr[at] = req;
      hdr[nw] = nfca_pkg::FREE_MARK | (left - HB);
      here[nw] = 1'b1;
      back[nw] = at + 1;
      after = nw + span(nw);
      if (after < SLOTS) back[after] = nw + 1;
      rover = nw;
      rover_ok = 1'b1;
      used_bytes += req + HB;
      n_chunks += 1;
    end else begin
      hdr[at] = sz;
      used_bytes += sz;
      rover_ok = find_free(at, 0, nxt);
      rover = rover_ok ? nxt : 0;
    end
    g.status = nfca_pkg::ST_OK;
    g.offset = 16'(at * 4 + HB);
    live_offsets.push_back(at * 4 + HB);
  endfunction

  function automatic nfca_pkg::status_t arena_release(int unsigned addr);
    int unsigned hw, nw, pw, plink, merged, after;
    bit has_next;
    if (addr < HB || (addr & nfca_pkg::ROUND_MASK) != 0) return nfca_pkg::ST_BADFREE;
    hw = (addr - HB) / 4;
    if (hw >= SLOTS || !here[hw] || (hdr[hw] & nfca_pkg::FREE_MARK) != 0)
      return nfca_pkg::ST_BADFREE;
    foreach (live_offsets[i])
      if (live_offsets[i] == addr) begin
        live_offsets.delete(i);
        break;
      end
    hdr[hw] |= nfca_pkg::FREE_MARK;
    used_bytes -= hdr[hw] & nfca_pkg::SIZE_FIELD;
    nw = hw + span(hw);
    has_next = nw < SLOTS;
    if (has_next && (hdr[nw] & nfca_pkg::FREE_MARK) != 0) begin
      merged = (hdr[hw] & nfca_pkg::SIZE_FIELD) + (hdr[nw] & nfca_pkg::SIZE_FIELD) + HB;
      after = nw + span(nw);
      hdr[hw] = nfca_pkg::FREE_MARK | (merged & nfca_pkg::SIZE_FIELD);
      hdr[nw] = 0;
      here[nw] = 0;
      back[nw] = 0;
      if (rover_ok && rover == nw) rover = hw;
      has_next = after < SLOTS;
      nw = after;
      if (has_next) back[nw] = hw + 1;
      used_bytes -= HB;
      n_chunks -= 1;
    end
    plink = back[hw];
    if (plink != 0 && plink <= SLOTS) begin
      pw = plink - 1;
      if ((hdr[pw] & nfca_pkg::FREE_MARK) != 0) begin
        merged = (hdr[pw] & nfca_pkg::SIZE_FIELD) + (hdr[hw] & nfca_pkg::SIZE_FIELD) + HB;
        hdr[pw] = nfca_pkg::FREE_MARK | (merged & nfca_pkg::SIZE_FIELD);
        hdr[hw] = 0;
        here[hw] = 0;
        back[hw] = 0;
        if (rover_ok && rover == hw) rover = pw;
        if (has_next) back[nw] = pw + 1;
        used_bytes -= HB;
        n_chunks -= 1;
      end
    end
    return nfca_pkg::ST_OK;
  endfunction

  function automatic void predict_request(logic op, logic [16:0] size, logic [15:0] addr);
    grant_t g;
    g.offset = '0;
    g.status = nfca_pkg::ST_OK;
    if (op == 1'b0) arena_alloc(size, g);
    else g.status = arena_release(addr);
    g.used = 17'(used_bytes);
    g.chunks = 12'(n_chunks);
    grants_due.push_back(g);
  endfunction

  // driver
  always @(posedge clk) begin
    int idle_pct;
    request_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request(in_op, in_request_size, in_free_address);
        n_accepted++;
      end
      if (!start || !busy) begin
        idle_pct = (n_accepted < 620) ? 14 : (n_accepted < 1240) ? 58 : 0;
        if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          r = pending.pop_front();
          start <= 1'b1;
          in_op <= r.op;
          in_request_size <= r.size;
          in_free_address <= r.addr;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result: offset %0d status %0d", out_data_offset, out_status);
        n_errors++;
      end else begin
        g = grants_due.pop_front();
        if (out_data_offset !== g.offset) begin
          $error("data_offset: expected %0d, got %0d", g.offset, out_data_offset);
          n_errors++;
        end
        if (out_status !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, out_status);
          n_errors++;
        end
        if (out_bytes_in_use !== g.used) begin
          $error("bytes_in_use: expected %0d, got %0d", g.used, out_bytes_in_use);
          n_errors++;
        end
        if (out_chunks_in_use !== g.chunks) begin
          $error("chunks_in_use: expected %0d, got %0d", g.chunks, out_chunks_in_use);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic request_t mk(logic op, logic [16:0] size, logic [15:0] addr);
    request_t r;
    r.op = op;
    r.size = size;
    r.addr = addr;
    return r;
  endfunction

  function automatic request_t random_request();
    int unsigned pick, a;
    pick = $urandom_range(99);
    if (pick < 55) begin
      pick = $urandom_range(99);
      if (pick < 3) return mk(1'b0, 17'd0, 16'($urandom));
      if (pick < 70) return mk(1'b0, 17'($urandom_range(256, 1)), 16'($urandom));
      if (pick < 94) return mk(1'b0, 17'($urandom_range(2048, 1)), 16'($urandom));
      return mk(1'b0, 17'($urandom_range(65536, 1)), 16'($urandom));
    end
    pick = $urandom_range(99);
    if (pick < 75 && live_offsets.size() > 0) begin
      a = live_offsets[$urandom_range(live_offsets.size() - 1)];
      return mk(1'b1, 17'($urandom), 16'(a));
    end
    if (pick < 85 && live_offsets.size() > 0) begin
      a = live_offsets[$urandom_range(live_offsets.size() - 1)] + 4 * $urandom_range(3, 1);
      return mk(1'b1, 17'($urandom), 16'(a));
    end
    return mk(1'b1, 17'($urandom), 16'($urandom));
  endfunction

  initial begin
    request_t plan [$];
    arena_reset();
    // zero size, split, no space, bad releases, double release, merges,
    // whole-arena grants with and without a remainder too small to split
    plan = '{mk(0, 0, 0), mk(0, 1, 0), mk(0, 5, 0), mk(0, 65536, 0),
             mk(1, 0, 0), mk(1, 0, 50), mk(1, 0, 44), mk(1, 0, 65535),
             mk(1, 0, 65532), mk(1, 0, 104), mk(1, 0, 48), mk(1, 0, 48),
             mk(1, 0, 100), mk(0, 65440, 0), mk(0, 4, 0), mk(1, 0, 48),
             mk(0, 65488, 0), mk(1, 131071, 65535), mk(0, 65489, 0),
             mk(0, 3, 0), mk(1, 0, 48)};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      wait (pending.size() < 2);
      pending.push_back(plan[i]);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      wait (pending.size() < 2);
      pending.push_back(random_request());
    end
    wait (pending.size() == 0);
    @(posedge clk);
    wait (!start && grants_due.size() == 0);
    repeat (60) @(posedge clk);
    if (n_errors == 0 && grants_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
